// ----- rtl/core/i2c_master_bit_engine_assert.svh -----
// Assertion macros shared by the I2C master bit engine modules.
`ifndef I2C_MASTER_BIT_ENGINE_ASSERT_SVH
`define I2C_MASTER_BIT_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS

// Same-cycle implication, checked outside reset.
`define I2CBE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("%m: assertion failed");

// Next-cycle implication, checked outside reset.
`define I2CBE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("%m: assertion failed");

`else

`define I2CBE_ASSERT_IMP(label, clk, rst_n, ante, cons)
`define I2CBE_ASSERT_NXT(label, clk, rst_n, ante, cons)

`endif

`endif

// ----- rtl/core/i2cbe_pkg.sv -----
// Types, codes and step decode for the I2C master bit engine.
package i2cbe_pkg;

  localparam int unsigned TickW      = 16;
  localparam logic [TickW-1:0] StepTicksRst = 16'd500;
  localparam int unsigned StepIdxW   = 5;
  localparam logic [StepIdxW-1:0] TxLastIdx = 5'd23;
  localparam logic [StepIdxW-1:0] RxLastIdx = 5'd24;

  // Command kinds carried on the input tuser
  typedef enum logic [2:0] {
    KIND_START   = 3'd0,
    KIND_STOP    = 3'd1,
    KIND_TX_BYTE = 3'd2,
    KIND_RX_BYTE = 3'd3,
    KIND_TX_ACK  = 3'd4,
    KIND_RX_ACK  = 3'd5
  } kind_e;

  // Pin step action carried on the output tuser
  typedef enum logic [1:0] {
    ACT_SCL    = 2'd0,
    ACT_SDA    = 2'd1,
    ACT_SAMPLE = 2'd2
  } action_e;

  // Bit phase inside one clocked data bit
  typedef enum logic [1:0] {
    PH_A = 2'd0,
    PH_B = 2'd1,
    PH_C = 2'd2
  } phase_e;

  typedef enum logic {
    ST_IDLE = 1'b0,
    ST_RUN  = 1'b1
  } state_e;

  typedef struct packed {
    action_e action;
    logic    level;
    logic    last;
  } step_t;

  // Controller to datapath
  typedef struct packed {
    logic start;  // latch a new command
    logic load;   // emit the current step into the output register
  } cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic tick_done;
    logic out_busy;
    logic step_last;
  } sts_t;

  // One pin step from the command kind and its position
  function automatic step_t step_decode(
    input logic [2:0]          kind,
    input logic [StepIdxW-1:0] idx,
    input phase_e              phase,
    input logic                tx_msb,
    input logic                smp_msb,
    input logic                ack
  );
    step_t s;
    s = '{action: ACT_SCL, level: 1'b0, last: 1'b0};
    case (kind)
      KIND_START: begin
        case (idx)
          5'd0:    s = '{action: ACT_SDA, level: 1'b1, last: 1'b0};
          5'd1:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
          5'd2:    s = '{action: ACT_SDA, level: 1'b0, last: 1'b0};
          default: s = '{action: ACT_SCL, level: 1'b0, last: 1'b1};
        endcase
      end
      KIND_STOP: begin
        case (idx)
          5'd0:    s = '{action: ACT_SDA, level: 1'b0, last: 1'b0};
          5'd1:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
          default: s = '{action: ACT_SDA, level: 1'b1, last: 1'b1};
        endcase
      end
      KIND_TX_BYTE: begin
        case (phase)
          PH_A:    s = '{action: ACT_SDA, level: tx_msb, last: 1'b0};
          PH_B:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
          default: s = '{action: ACT_SCL, level: 1'b0, last: (idx == TxLastIdx)};
        endcase
      end
      KIND_RX_BYTE: begin
        if (idx == '0) begin
          s = '{action: ACT_SDA, level: 1'b1, last: 1'b0};
        end else begin
          case (phase)
            PH_A:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
            PH_B:    s = '{action: ACT_SAMPLE, level: smp_msb, last: 1'b0};
            default: s = '{action: ACT_SCL, level: 1'b0, last: (idx == RxLastIdx)};
          endcase
        end
      end
      KIND_TX_ACK: begin
        case (idx)
          5'd0:    s = '{action: ACT_SDA, level: ack, last: 1'b0};
          5'd1:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
          default: s = '{action: ACT_SCL, level: 1'b0, last: 1'b1};
        endcase
      end
      KIND_RX_ACK: begin
        case (idx)
          5'd0:    s = '{action: ACT_SDA, level: 1'b1, last: 1'b0};
          5'd1:    s = '{action: ACT_SCL, level: 1'b1, last: 1'b0};
          5'd2:    s = '{action: ACT_SAMPLE, level: smp_msb, last: 1'b0};
          default: s = '{action: ACT_SCL, level: 1'b0, last: 1'b1};
        endcase
      end
      default: s = '{action: ACT_SCL, level: 1'b0, last: 1'b1};
    endcase
    return s;
  endfunction

endpackage

// ----- rtl/core/i2cbe_ctrl.sv -----
// Command sequencer: accepts commands and paces the pin steps.
`include "i2c_master_bit_engine_assert.svh"

module i2cbe_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [2:0]        s_axis_tuser,    // kind
  input  i2cbe_pkg::sts_t   sts_i,
  output i2cbe_pkg::cmd_t   cmd_o
);

  i2cbe_pkg::state_e state_q, state_d;
  logic              kind_ok;

  // Kinds past receive ack are taken and dropped
  assign kind_ok = s_axis_tuser inside {[i2cbe_pkg::KIND_START : i2cbe_pkg::KIND_RX_ACK]};

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      i2cbe_pkg::ST_IDLE: begin
        if (s_axis_tvalid && kind_ok) state_d = i2cbe_pkg::ST_RUN;
      end
      i2cbe_pkg::ST_RUN: begin
        if (sts_i.tick_done && !sts_i.out_busy && sts_i.step_last) begin
          state_d = i2cbe_pkg::ST_IDLE;
        end
      end
      default: state_d = i2cbe_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    s_axis_tready = 1'b0;
    cmd_o         = '0;
    case (state_q)
      i2cbe_pkg::ST_IDLE: begin
        s_axis_tready = 1'b1;
        cmd_o.start   = s_axis_tvalid && kind_ok;
      end
      i2cbe_pkg::ST_RUN: begin
        cmd_o.load = sts_i.tick_done && !sts_i.out_busy;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= i2cbe_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  `I2CBE_ASSERT_IMP(a_no_start_busy, clk_i, rst_ni, state_q == i2cbe_pkg::ST_RUN, !cmd_o.start)
  `I2CBE_ASSERT_IMP(a_load_when_free, clk_i, rst_ni, cmd_o.load, !sts_i.out_busy)
  `I2CBE_ASSERT_NXT(a_last_to_idle, clk_i, rst_ni, cmd_o.load && sts_i.step_last,
                    state_q == i2cbe_pkg::ST_IDLE)

endmodule

// ----- rtl/core/i2cbe_datapath.sv -----
// Datapath: command registers, step timer, step decode and output register.
`include "i2c_master_bit_engine_assert.svh"

module i2cbe_datapath (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_valid_i,
  input  logic [15:0]     cfg_data_i,
  input  logic [23:0]     s_axis_tdata,    // tx_byte, ack_out, sda_samples, pad
  input  logic [2:0]      s_axis_tuser,    // kind
  output logic            m_axis_tvalid,
  input  logic            m_axis_tready,
  output logic [15:0]     m_axis_tdata,    // level, rx_byte, ack_in, pad
  output logic [1:0]      m_axis_tuser,    // action
  output logic            m_axis_tlast,
  input  i2cbe_pkg::cmd_t cmd_i,
  output i2cbe_pkg::sts_t sts_o
);

  localparam int unsigned TW = i2cbe_pkg::TickW;

  logic [TW-1:0]                   step_ticks_q;
  logic [TW-1:0]                   tick_q;
  logic [TW-1:0]                   limit;
  logic [2:0]                      kind_q;
  logic [7:0]                      tx_q;
  logic [7:0]                      smp_q;
  logic                            ack_q;
  logic [7:0]                      shift_q;
  logic [i2cbe_pkg::StepIdxW-1:0]  idx_q;
  i2cbe_pkg::phase_e               phase_q;
  i2cbe_pkg::step_t                step;
  logic                            phase_adv;
  logic                            out_valid_q;
  i2cbe_pkg::action_e              out_act_q;
  logic                            out_level_q;
  logic [7:0]                      out_rx_q;
  logic                            out_ack_q;
  logic                            out_last_q;

  // Step length; zero is taken as one
  assign limit = (step_ticks_q == '0) ? TW'(1) : step_ticks_q;

  always_comb begin
    sts_o.tick_done = ({1'b0, tick_q} + (TW+1)'(1)) >= {1'b0, limit};
    sts_o.out_busy  = out_valid_q && !m_axis_tready;
    sts_o.step_last = step.last;
  end

  assign step = i2cbe_pkg::step_decode(kind_q, idx_q, phase_q, tx_q[7], smp_q[7], ack_q);

  // Bit phase moves for the byte commands, after the leading release on receive
  assign phase_adv = (kind_q == i2cbe_pkg::KIND_TX_BYTE) ||
                     ((kind_q == i2cbe_pkg::KIND_RX_BYTE) && (idx_q != '0));

  // Step length register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_ticks_q <= i2cbe_pkg::StepTicksRst;
    end else if (cfg_valid_i) begin
      step_ticks_q <= cfg_data_i;
    end
  end

  // Step timer, position and receive shifter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tick_q  <= '0;
      idx_q   <= '0;
      phase_q <= i2cbe_pkg::PH_A;
      shift_q <= '0;
    end else if (cmd_i.start) begin
      tick_q  <= '0;
      idx_q   <= '0;
      phase_q <= i2cbe_pkg::PH_A;
      shift_q <= '0;
    end else if (cmd_i.load) begin
      tick_q <= '0;
      idx_q  <= step.last ? '0 : idx_q + 1'b1;
      if (phase_adv) begin
        phase_q <= (phase_q == i2cbe_pkg::PH_C) ? i2cbe_pkg::PH_A
                                                : i2cbe_pkg::phase_e'(phase_q + 2'd1);
      end
      if ((kind_q == i2cbe_pkg::KIND_RX_BYTE) && (step.action == i2cbe_pkg::ACT_SAMPLE)) begin
        shift_q <= {shift_q[6:0], smp_q[7]};
      end
    end else if (!sts_o.tick_done) begin
      tick_q <= tick_q + 1'b1;
    end
  end

  // Command payload, shifted MSB first as bits go out or come in
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      kind_q <= s_axis_tuser;
      tx_q   <= s_axis_tdata[7:0];
      ack_q  <= s_axis_tdata[8];
      smp_q  <= s_axis_tdata[16:9];
    end else if (cmd_i.load) begin
      if ((kind_q == i2cbe_pkg::KIND_TX_BYTE) && (phase_q == i2cbe_pkg::PH_C)) begin
        tx_q <= {tx_q[6:0], 1'b0};
      end
      if ((kind_q == i2cbe_pkg::KIND_RX_BYTE) && (step.action == i2cbe_pkg::ACT_SAMPLE)) begin
        smp_q <= {smp_q[6:0], 1'b0};
      end
    end
  end

  // Output register valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  // Output register payload
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      out_act_q   <= step.action;
      out_level_q <= step.level;
      out_last_q  <= step.last;
      out_rx_q    <= (step.last && (kind_q == i2cbe_pkg::KIND_RX_BYTE)) ? shift_q : 8'h00;
      out_ack_q   <= step.last && (kind_q == i2cbe_pkg::KIND_RX_ACK) && smp_q[7];
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_act_q;
  assign m_axis_tlast  = out_last_q;
  assign m_axis_tdata  = {6'b0, out_ack_q, out_rx_q, out_level_q};

  `I2CBE_ASSERT_IMP(a_idx_range, clk_i, rst_ni, 1'b1, idx_q <= i2cbe_pkg::RxLastIdx)
  `I2CBE_ASSERT_IMP(a_phase_range, clk_i, rst_ni, 1'b1, phase_q != 2'd3)
  `I2CBE_ASSERT_NXT(a_load_shows, clk_i, rst_ni, cmd_i.load, out_valid_q)

endmodule

// ----- rtl/core/i2c_master_bit_engine.sv -----
// I2C master bit engine top level: command in, pin steps out.
//
//  Channel   Dir  Handshake                    Payload
//  s_axis    in   s_axis_tvalid/s_axis_tready  tuser kind; tdata tx_byte, ack_out, sda_samples
//  m_axis    out  m_axis_tvalid/m_axis_tready  tuser action; tdata level, rx_byte, ack_in; tlast
//  cfg       in   cfg_valid_i/cfg_ready_o      cfg_data_i step_ticks
//
// Each pin step is paced by the step timer against step_ticks (zero taken as one) before
// its beat is loaded; a command has 3 to 25 steps.
// One command runs at a time; the next is taken in the idle cycle after the last load.
// A stalled output beat freezes the timer at step end until the beat is taken.
// Reset leaves step_ticks at 500 and the engine idle; kinds 6 and 7 are dropped.
module i2c_master_bit_engine (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [15:0] cfg_data_i,     // step_ticks
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [23:0] s_axis_tdata,   // [7:0] tx_byte, [8] ack_out, [16:9] sda_samples
  input  logic [2:0]  s_axis_tuser,   // [2:0] kind
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [0] level, [8:1] rx_byte, [9] ack_in
  output logic [1:0]  m_axis_tuser,   // [1:0] action
  output logic        m_axis_tlast
);

  i2cbe_pkg::cmd_t cmd;
  i2cbe_pkg::sts_t sts;

  assign cfg_ready_o = 1'b1;

  i2cbe_ctrl u_ctrl (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tuser  (s_axis_tuser),
    .sts_i         (sts),
    .cmd_o         (cmd)
  );

  i2cbe_datapath u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast),
    .cmd_i         (cmd),
    .sts_o         (sts)
  );

endmodule
